// File: hw/rtl/gaus_pkg.sv
package gaus_pkg;

    // Sizes of the system and of the fixed-point words
    localparam int MAX_N     = 8;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int NCOLS     = MAX_N + 1;
    localparam int WK_DEPTH  = MAX_N * NCOLS;
    localparam int ADDR_W    = $clog2(WK_DEPTH);
    localparam int ROW_W     = $clog2(MAX_N);
    localparam int COL_W     = $clog2(MAX_N + 1);
    localparam int RHS_COL   = MAX_N;
    localparam int RESET_SIZE = 8;
    localparam int CFG_W     = 4;

    // Arithmetic widths
    localparam int PROD_W = 2 * DATA_W;
    localparam int MUL_W  = PROD_W - FRAC_BITS;
    localparam int ACC_W  = MUL_W + 4;
    localparam int DIV_W  = DATA_W + FRAC_BITS;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    // Stream widths, padded to whole bytes
    localparam int IN_W   = ((ROW_W + COL_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_W  = ((ROW_W + DATA_W + 7) / 8) * 8;

    typedef logic signed [DATA_W-1:0] fx_t;

    typedef struct packed {
        logic done;
        logic sat;
        fx_t  quot;
    } div_res_t;

    localparam logic signed [ACC_W-1:0] FX_MAX_W =
        {{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] FX_MIN_W =
        {{(ACC_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

    // Scale a full product back to fixed point, truncating toward zero
    function automatic logic signed [MUL_W-1:0] fx_scale(input logic signed [PROD_W-1:0] p);
        logic signed [MUL_W-1:0] t;
        t = MUL_W'(p >>> FRAC_BITS);
        if (p[PROD_W-1] && (p[FRAC_BITS-1:0] != '0))
            t = t + MUL_W'(1);
        return t;
    endfunction

    function automatic logic sat_hit(input logic signed [ACC_W-1:0] v);
        return (v > FX_MAX_W) || (v < FX_MIN_W);
    endfunction

    function automatic fx_t sat_fx(input logic signed [ACC_W-1:0] v);
        fx_t r;
        if (v > FX_MAX_W)
            r = FX_MAX_W[DATA_W-1:0];
        else if (v < FX_MIN_W)
            r = FX_MIN_W[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // Word address of row r, column c in the row-major store
    function automatic logic [ADDR_W-1:0] wk_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
        return ADDR_W'(int'(r) * NCOLS + int'(c));
    endfunction

endpackage

// File: hw/rtl/gaus_div.sv
module gaus_div import gaus_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     start,
    input  fx_t      num,
    input  fx_t      den,
    output div_res_t res
);

    logic                busy_reg;
    logic [DCNT_W-1:0]   cnt_reg;
    logic [DATA_W-1:0]   rem_reg;
    logic [DIV_W-1:0]    dvd_reg;
    logic [DATA_W-1:0]   dsr_reg;
    logic                neg_reg;
    div_res_t            res_reg;

    logic [DATA_W:0]     rem_sh;
    logic                ge;
    logic [DATA_W-1:0]   num_mag;
    logic [DATA_W-1:0]   den_mag;
    logic                ovf_pos;
    logic                ovf_neg;

    assign num_mag = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
    assign den_mag = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);

    // One restoring step: shift in the next dividend bit, try the subtract
    assign rem_sh = {rem_reg, dvd_reg[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, dsr_reg};

    assign ovf_pos = dvd_reg[DIV_W-1:DATA_W-1] != '0;
    assign ovf_neg = (dvd_reg[DIV_W-1:DATA_W] != '0) ||
                     (dvd_reg[DATA_W-1] && (dvd_reg[DATA_W-2:0] != '0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            res_reg.done <= 1'b0;
        end else begin
            res_reg.done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_W);
                rem_reg  <= '0;
                dvd_reg  <= {num_mag, {FRAC_BITS{1'b0}}};
                dsr_reg  <= den_mag;
                neg_reg  <= num[DATA_W-1] ^ den[DATA_W-1];
            end else if (busy_reg && (cnt_reg != '0)) begin
                rem_reg <= ge ? DATA_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[DATA_W-1:0];
                dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
            end else if (busy_reg) begin
                // Apply the sign and saturate the quotient
                busy_reg     <= 1'b0;
                res_reg.done <= 1'b1;
                if (neg_reg) begin
                    res_reg.sat  <= ovf_neg;
                    res_reg.quot <= ovf_neg ? FX_MIN_W[DATA_W-1:0]
                                            : fx_t'(~dvd_reg[DATA_W-1:0] + 1'b1);
                end else begin
                    res_reg.sat  <= ovf_pos;
                    res_reg.quot <= ovf_pos ? FX_MAX_W[DATA_W-1:0]
                                            : fx_t'(dvd_reg[DATA_W-1:0]);
                end
            end
        end
    end

    assign res = res_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        res_reg.done |-> $past(busy_reg)) else $error("quotient without a division");

    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (cnt_reg == '0) && !start) |=> res_reg.done)
        else $error("division did not finish");

endmodule

// File: hw/rtl/gauss_elimination_solver.sv
// Linear system solver, Gaussian elimination with back substitution, Q16.16.
// Input stream s_*: one matrix element per transaction, addressed by row and
// column; column equal to system_size is the right-hand side. s_tlast set on
// a transaction writes that element and then starts a solve.
// Result stream m_*: system_size transactions, unknowns 0 .. n-1 in order,
// m_tlast on the last one; m_tuser carries the singular and overflow flags.
// cfg_*: writes system_size (1 .. 8, other values clamp); the user must write
// it only while idle, as the block does not enforce this. A solve copies the
// 72-word matrix into a work memory, then eliminates: per row below a pivot
// one serial 48-step division, and per updated element two reads and one
// write of the work memory, through S_U_RDP, S_U_RDA, S_U_MUL and S_U_WR.
// Back substitution takes each product through S_B_RD, S_B_MUL and S_B_ACC,
// plus one division per unknown. Results leave one per cycle while the
// receiver is ready.
// The input is not accepted during a solve or while results are emitted;
// a stalled receiver holds the result register and the sequencer waits.
// Reset sets system_size to 8, returns the sequencer to idle and clears the
// flags and the result valid; the matrix must be written before it is solved.
module gauss_elimination_solver import gaus_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // row_index, col_index, coef_value
    input  logic             s_tlast,   // start_solve
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // unknown_index, solution_value
    output logic [1:0]       m_tuser,   // singular, overflowed
    output logic             m_tlast,   // last_result
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_COPY, S_PIV_RD, S_PIV_CHK, S_SRCH_RD, S_SRCH_CHK,
        S_ROW_RD, S_ROW_DIV, S_ROW_DIVW, S_U_RDP, S_U_RDA, S_U_MUL, S_U_WR,
        S_NEXT_J, S_B_INIT, S_B_RD, S_B_MUL, S_B_ACC, S_B_RHS, S_B_PIV,
        S_B_DIVW, S_B_NEXT, S_OUT
    } state_t;

    localparam int OUT_PAD = OUT_W - ROW_W - DATA_W;

    state_t               state_reg;
    logic [CFG_W-1:0]     size_reg;
    logic [ADDR_W:0]      cnt_reg;
    logic                 cp_vld_reg;
    logic [ADDR_W-1:0]    cp_addr_reg;
    logic [COL_W-1:0]     j_reg, i_reg, r_reg, k_reg;
    logic [ROW_W-1:0]     perm_reg [MAX_N];
    fx_t                  piv_reg, m_reg, p_reg, a_reg, d_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    fx_t                  sol_reg [MAX_N];
    logic                 sing_reg, sat_reg;
    logic                 m_valid_reg, m_last_reg, m_sing_reg, m_ovf_reg;
    logic [ROW_W-1:0]     m_idx_reg;
    fx_t                  m_val_reg;

    // Memories
    fx_t                  mat_mem [WK_DEPTH];
    fx_t                  wk_mem  [WK_DEPTH];
    fx_t                  mat_rdata;
    fx_t                  wk_rdata;
    logic [ADDR_W-1:0]    wk_raddr, wk_waddr;
    logic                 wk_we;
    fx_t                  wk_wdata;

    logic [COL_W-1:0]     n_eff;
    logic [COL_W-1:0]     n_m1;
    logic [ROW_W-1:0]     in_row;
    logic [COL_W-1:0]     in_col;
    fx_t                  in_coef;
    logic                 in_acc;
    logic                 mat_we;
    logic [ADDR_W-1:0]    mat_waddr;
    logic [ROW_W-1:0]     pj, pi, pr;
    fx_t                  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_out;
    logic signed [ACC_W-1:0]  upd_diff, rhs_diff;
    logic                 div_start;
    fx_t                  div_num, div_den;
    div_res_t             div_res;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;

    assign in_row  = s_tdata[ROW_W-1:0];
    assign in_col  = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign in_coef = s_tdata[ROW_W+COL_W+DATA_W-1:ROW_W+COL_W];

    // Clamp the configured size into 1 .. MAX_N
    always_comb begin
        priority if (size_reg == '0)
            n_eff = COL_W'(1);
        else if (int'(size_reg) > MAX_N)
            n_eff = COL_W'(MAX_N);
        else
            n_eff = COL_W'(size_reg);
    end
    assign n_m1 = n_eff - 1'b1;

    // Element writes: columns past the right-hand side are dropped
    assign mat_we    = in_acc && (in_col <= n_eff);
    assign mat_waddr = (in_col == n_eff) ? wk_addr(in_row, COL_W'(RHS_COL))
                                         : wk_addr(in_row, in_col);

    always_ff @(posedge aclk) begin
        if (mat_we)
            mat_mem[mat_waddr] <= in_coef;
        mat_rdata <= mat_mem[cnt_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (wk_we)
            wk_mem[wk_waddr] <= wk_wdata;
        wk_rdata <= wk_mem[wk_raddr];
    end

    // Physical rows behind the logical pivot, target and search rows
    assign pj = perm_reg[j_reg[ROW_W-1:0]];
    assign pi = perm_reg[i_reg[ROW_W-1:0]];
    assign pr = perm_reg[r_reg[ROW_W-1:0]];

    // Work memory read address
    always_comb begin
        unique case (state_reg)
            S_PIV_RD:  wk_raddr = wk_addr(pj, j_reg);
            S_SRCH_RD: wk_raddr = wk_addr(pr, j_reg);
            S_ROW_RD:  wk_raddr = wk_addr(pi, j_reg);
            S_U_RDP:   wk_raddr = wk_addr(pj, k_reg);
            S_U_RDA:   wk_raddr = wk_addr(pi, k_reg);
            S_B_RD:    wk_raddr = (k_reg == n_eff) ? wk_addr(pi, COL_W'(RHS_COL))
                                                   : wk_addr(pi, k_reg);
            S_B_RHS:   wk_raddr = wk_addr(pi, i_reg);
            default:   wk_raddr = '0;
        endcase
    end

    // Shared multiplier
    assign mul_a   = (state_reg == S_U_MUL) ? m_reg : wk_rdata;
    assign mul_b   = (state_reg == S_U_MUL) ? p_reg : sol_reg[k_reg[ROW_W-1:0]];
    assign mul_out = mul_a * mul_b;

    assign upd_diff = ACC_W'(a_reg) - ACC_W'(fx_scale(prod_reg));
    assign rhs_diff = ACC_W'(wk_rdata) - acc_reg;

    // Work memory write: copy sweep or row update
    always_comb begin
        wk_we    = 1'b0;
        wk_waddr = cp_addr_reg;
        wk_wdata = mat_rdata;
        if (cp_vld_reg) begin
            wk_we = 1'b1;
        end else if (state_reg == S_U_WR) begin
            wk_we    = 1'b1;
            wk_waddr = wk_addr(pi, k_reg);
            wk_wdata = sat_fx(upd_diff);
        end
    end

    assign div_start = (state_reg == S_ROW_DIV) ||
                       ((state_reg == S_B_PIV) && (wk_rdata != '0));
    assign div_num   = (state_reg == S_ROW_DIV) ? wk_rdata : d_reg;
    assign div_den   = (state_reg == S_ROW_DIV) ? piv_reg : wk_rdata;

    gaus_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .res     (div_res)
    );

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            size_reg    <= CFG_W'(RESET_SIZE);
            cp_vld_reg  <= 1'b0;
            sing_reg    <= 1'b0;
            sat_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready)
                size_reg <= cfg_data;
            if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;
            cp_vld_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc && s_tlast) begin
                        cnt_reg  <= '0;
                        sat_reg  <= 1'b0;
                        sing_reg <= 1'b0;
                        for (int q = 0; q < MAX_N; q++)
                            perm_reg[q] <= ROW_W'(q);
                        state_reg <= S_COPY;
                    end
                end
                S_COPY: begin
                    if (int'(cnt_reg) < WK_DEPTH) begin
                        cp_vld_reg  <= 1'b1;
                        cp_addr_reg <= cnt_reg[ADDR_W-1:0];
                        cnt_reg     <= cnt_reg + 1'b1;
                    end else if (!cp_vld_reg) begin
                        j_reg <= '0;
                        i_reg <= n_m1;
                        state_reg <= (n_eff == COL_W'(1)) ? S_B_INIT : S_PIV_RD;
                    end
                end
                S_PIV_RD: state_reg <= S_PIV_CHK;
                S_PIV_CHK: begin
                    if (wk_rdata != '0) begin
                        piv_reg   <= wk_rdata;
                        i_reg     <= j_reg + 1'b1;
                        state_reg <= S_ROW_RD;
                    end else begin
                        r_reg     <= j_reg + 1'b1;
                        state_reg <= S_SRCH_RD;
                    end
                end
                S_SRCH_RD: begin
                    if (r_reg == n_eff) begin
                        sing_reg  <= 1'b1;
                        state_reg <= S_NEXT_J;
                    end else begin
                        state_reg <= S_SRCH_CHK;
                    end
                end
                S_SRCH_CHK: begin
                    if (wk_rdata != '0) begin
                        // Swap the rows by their entries in the permutation
                        perm_reg[j_reg[ROW_W-1:0]] <= pr;
                        perm_reg[r_reg[ROW_W-1:0]] <= pj;
                        piv_reg   <= wk_rdata;
                        i_reg     <= j_reg + 1'b1;
                        state_reg <= S_ROW_RD;
                    end else begin
                        r_reg     <= r_reg + 1'b1;
                        state_reg <= S_SRCH_RD;
                    end
                end
                S_ROW_RD: state_reg <= (i_reg == n_eff) ? S_NEXT_J : S_ROW_DIV;
                S_ROW_DIV: state_reg <= S_ROW_DIVW;
                S_ROW_DIVW: begin
                    if (div_res.done) begin
                        m_reg <= div_res.quot;
                        if (div_res.sat)
                            sat_reg <= 1'b1;
                        k_reg     <= j_reg;
                        state_reg <= S_U_RDP;
                    end
                end
                S_U_RDP: state_reg <= S_U_RDA;
                S_U_RDA: begin
                    p_reg     <= wk_rdata;
                    state_reg <= S_U_MUL;
                end
                S_U_MUL: begin
                    a_reg     <= wk_rdata;
                    prod_reg  <= mul_out;
                    state_reg <= S_U_WR;
                end
                S_U_WR: begin
                    if (sat_hit(upd_diff))
                        sat_reg <= 1'b1;
                    if (k_reg == COL_W'(RHS_COL)) begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_ROW_RD;
                    end else begin
                        k_reg     <= (k_reg == n_m1) ? COL_W'(RHS_COL) : k_reg + 1'b1;
                        state_reg <= S_U_RDP;
                    end
                end
                S_NEXT_J: begin
                    if (j_reg + 1'b1 == n_m1) begin
                        i_reg     <= n_m1;
                        state_reg <= S_B_INIT;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_PIV_RD;
                    end
                end
                S_B_INIT: begin
                    acc_reg   <= '0;
                    k_reg     <= i_reg + 1'b1;
                    state_reg <= S_B_RD;
                end
                S_B_RD: state_reg <= (k_reg == n_eff) ? S_B_RHS : S_B_MUL;
                S_B_MUL: begin
                    prod_reg  <= mul_out;
                    state_reg <= S_B_ACC;
                end
                S_B_ACC: begin
                    acc_reg   <= acc_reg + ACC_W'(fx_scale(prod_reg));
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= S_B_RD;
                end
                S_B_RHS: begin
                    d_reg <= sat_fx(rhs_diff);
                    if (sat_hit(rhs_diff))
                        sat_reg <= 1'b1;
                    state_reg <= S_B_PIV;
                end
                S_B_PIV: begin
                    if (wk_rdata == '0) begin
                        sing_reg <= 1'b1;
                        sol_reg[i_reg[ROW_W-1:0]] <= '0;
                        state_reg <= S_B_NEXT;
                    end else begin
                        state_reg <= S_B_DIVW;
                    end
                end
                S_B_DIVW: begin
                    if (div_res.done) begin
                        sol_reg[i_reg[ROW_W-1:0]] <= div_res.quot;
                        if (div_res.sat)
                            sat_reg <= 1'b1;
                        state_reg <= S_B_NEXT;
                    end
                end
                S_B_NEXT: begin
                    if (i_reg == '0) begin
                        k_reg     <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        i_reg     <= i_reg - 1'b1;
                        state_reg <= S_B_INIT;
                    end
                end
                S_OUT: begin
                    // Load the next unknown once the result register is free
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_idx_reg   <= k_reg[ROW_W-1:0];
                        m_val_reg   <= sol_reg[k_reg[ROW_W-1:0]];
                        m_sing_reg  <= sing_reg;
                        m_ovf_reg   <= sat_reg;
                        m_last_reg  <= (k_reg == n_m1);
                        if (k_reg == n_m1)
                            state_reg <= S_IDLE;
                        else
                            k_reg <= k_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, m_val_reg, m_idx_reg};
    assign m_tuser  = {m_ovf_reg, m_sing_reg};
    assign m_tlast  = m_last_reg;

    a_wk_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wk_we |-> (int'(wk_waddr) < WK_DEPTH)) else $error("work write out of range");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (COL_W'(m_idx_reg) == n_m1))
        else $error("last flag on wrong unknown");

    a_solve_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tlast) |=> (!sat_reg && !sing_reg && (state_reg == S_COPY)))
        else $error("solve start did not clear flags");

endmodule

// File: tb/testbench.sv
module testbench;
    import gaus_pkg::*;

    typedef struct {
        logic [2:0]  idx;
        logic [31:0] value;
        logic        sing;
        logic        ovf;
        logic        last;
    } solution_t;

    // Solver model plus the queue of solution components still to arrive
    class solution_board;
        int          coef[MAX_N][NCOLS];
        int          sol[MAX_N];
        bit          sat_flag;
        int unsigned size_reg;
        solution_t   pending[$];
        int          errors;

        function new();
            size_reg = RESET_SIZE;
            errors = 0;
            foreach (coef[r, c]) coef[r][c] = 0;
            foreach (sol[i]) sol[i] = 0;
        endfunction

        function int clip(longint v);
            if (v > 64'sd2147483647) begin
                sat_flag = 1;
                return 32'sh7fffffff;
            end
            if (v < -64'sd2147483648) begin
                sat_flag = 1;
                return 32'sh80000000;
            end
            return int'(v);
        endfunction

        function longint qmul(int a, int b);
            return (longint'(a) * longint'(b)) / 65536;
        endfunction

        function int qdiv(int num, int den);
            return clip((longint'(num) * 65536) / longint'(den));
        endfunction

        function int unsigned active_n();
            if (size_reg < 1) return 1;
            if (size_reg > MAX_N) return MAX_N;
            return size_reg;
        endfunction

        // Eliminate with row swaps, then back substitute into sol[]
        function bit run_solve(int n);
            int  w[MAX_N][NCOLS];
            int  tmp;
            int  m;
            int  d;
            longint acc;
            bit  sing;
            w = coef;
            sat_flag = 0;
            sing = 0;
            for (int j = 0; j < n - 1; j++) begin
                if (w[j][j] == 0) begin
                    for (int r = j + 1; r < n; r++) begin
                        if (w[r][j] != 0) begin
                            for (int k = 0; k < NCOLS; k++) begin
                                tmp = w[j][k];
                                w[j][k] = w[r][k];
                                w[r][k] = tmp;
                            end
                            break;
                        end
                    end
                end
                if (w[j][j] == 0) begin
                    sing = 1;
                    continue;
                end
                for (int i = j + 1; i < n; i++) begin
                    m = qdiv(w[i][j], w[j][j]);
                    for (int k = j; k < n; k++)
                        w[i][k] = clip(longint'(w[i][k]) - qmul(m, w[j][k]));
                    w[i][RHS_COL] = clip(longint'(w[i][RHS_COL]) - qmul(m, w[j][RHS_COL]));
                end
            end
            for (int i = n - 1; i >= 0; i--) begin
                acc = 0;
                for (int j = i + 1; j < n; j++)
                    acc += qmul(w[i][j], sol[j]);
                d = clip(longint'(w[i][RHS_COL]) - acc);
                if (w[i][i] == 0) begin
                    sing = 1;
                    sol[i] = 0;
                end else begin
                    sol[i] = qdiv(d, w[i][i]);
                end
            end
            return sing;
        endfunction

        // Store one accepted element and queue a solution if requested
        function void note_element(logic [2:0] row, logic [3:0] col, logic [31:0] val,
                                   logic go);
            int        n;
            bit        sing;
            solution_t e;
            n = active_n();
            if (col < n)
                coef[row][col] = int'(val);
            else if (col == n)
                coef[row][RHS_COL] = int'(val);
            if (!go) return;
            sing = run_solve(n);
            for (int i = 0; i < n; i++) begin
                e.idx   = i[2:0];
                e.value = sol[i];
                e.sing  = sing;
                e.ovf   = sat_flag;
                e.last  = (i == n - 1);
                pending.push_back(e);
            end
        endfunction

        function void check_solution(solution_t got);
            solution_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result idx=%0d value=%h", $time, got.idx, got.value);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.idx !== e.idx) begin
                $display("%0t: unknown_index expected %0d actual %0d", $time, e.idx, got.idx);
                errors++;
            end
            if (got.value !== e.value) begin
                $display("%0t: solution_value[%0d] expected %h actual %h",
                         $time, e.idx, e.value, got.value);
                errors++;
            end
            if (got.sing !== e.sing) begin
                $display("%0t: singular expected %b actual %b", $time, e.sing, got.sing);
                errors++;
            end
            if (got.ovf !== e.ovf) begin
                $display("%0t: overflowed expected %b actual %b", $time, e.ovf, got.ovf);
                errors++;
            end
            if (got.last !== e.last) begin
                $display("%0t: last_result expected %b actual %b", $time, e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    localparam int ITEM_TARGET = 320;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int HOLD_CYCLES = 8000;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             s_tlast;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0]       m_tuser;
    logic             m_tlast;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    solution_board board;
    int  items_sent;
    int  cycle_count;
    bit  no_idle;
    int  hold_req;
    int  hold_seen;
    int  hold_left;

    gauss_elimination_solver uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Check result transactions and drive the receiver's ready
    always @(posedge aclk) begin
        solution_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.idx   = m_tdata[2:0];
            got.value = m_tdata[34:3];
            got.sing  = m_tuser[0];
            got.ovf   = m_tuser[1];
            got.last  = m_tlast;
            board.check_solution(got);
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(0, 99) >= 7);
        end
    end

    // Offer one element and hold it until the block takes it
    task automatic send_element(logic [2:0] row, logic [3:0] col, logic [31:0] val,
                                logic go);
        if (!no_idle && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({val, col, row});
        s_tlast  <= go;
        do @(posedge aclk); while (!s_tready);
        board.note_element(row, col, val, go);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_size(logic [3:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        board.size_reg = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Element value: mostly moderate, sometimes zero, full range or extreme
    function automatic logic [31:0] pick_coef(bit diag);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8) return 32'h0;
        if (sel < 16) return $urandom;
        if (sel < 20) return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
        if (diag)
            return ($urandom_range(0, 1) != 0) ? $urandom_range(20 << 16, 40 << 16)
                                               : -$urandom_range(20 << 16, 40 << 16);
        return $urandom_range(0, 8 << 16) - (4 << 16);
    endfunction

    // Load a whole n-by-(n+1) system and solve on its last element
    task automatic load_system(int n);
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= n; c++)
                send_element(3'(r), 4'(c), pick_coef(r == c), (r == n - 1) && (c == n));
    endtask

    // A few scattered writes, including ignored columns, then a solve
    task automatic touch_and_solve(int n);
        int cnt;
        cnt = $urandom_range(0, 4);
        repeat (cnt)
            send_element(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                         pick_coef(1'b0), 1'b0);
        send_element(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                     pick_coef(1'b0), 1'b1);
    endtask

    initial begin
        logic [3:0] sizes[$];
        int n;
        board = new();
        items_sent = 0;
        cycle_count = 0;
        no_idle = 0;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill every slot of the store at reset size, then solve it
        for (int r = 0; r < MAX_N; r++)
            for (int c = 0; c < NCOLS; c++)
                send_element(3'(r), 4'(c), pick_coef(r == c),
                             (r == MAX_N - 1) && (c == RHS_COL));
        wait_drained();

        // Extremes, an ignored column and a swap-forcing zero pivot at full size
        send_element(3'd7, 4'd8, 32'h7fffffff, 1'b1);
        send_element(3'd0, 4'd8, 32'h80000000, 1'b1);
        send_element(3'd2, 4'd15, 32'h12345678, 1'b1);
        send_element(3'd0, 4'd0, 32'h0, 1'b1);
        wait_drained();

        // One unknown: zero pivot in back substitution, then extremes
        write_size(4'd1);
        send_element(3'd0, 4'd0, 32'h0, 1'b1);
        send_element(3'd0, 4'd0, 32'h00000001, 1'b0);
        send_element(3'd0, 4'd1, 32'h7fffffff, 1'b1);
        send_element(3'd0, 4'd0, 32'hffffffff, 1'b0);
        send_element(3'd0, 4'd1, 32'h80000000, 1'b1);
        send_element(3'd5, 4'd2, 32'hdeadbeef, 1'b1);
        wait_drained();

        // Two unknowns with a whole zero column: no row to swap in
        write_size(4'd2);
        send_element(3'd0, 4'd0, 32'h0, 1'b0);
        send_element(3'd1, 4'd0, 32'h0, 1'b1);
        send_element(3'd1, 4'd0, 32'h00010000, 1'b1);
        wait_drained();

        // Random phases across sizes, clamped values included
        sizes = '{4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd9, 4'd4, 4'd2, 4'd7, 4'd6};
        while (items_sent < ITEM_TARGET) begin
            if (sizes.size() != 0)
                write_size(sizes.pop_front());
            else
                write_size(4'($urandom_range(0, 15)));
            n = board.active_n();
            no_idle = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(2, 5)) begin
                if (items_sent < ITEM_TARGET) begin
                    if (items_sent >= 150 && hold_req == 0)
                        hold_req++;
                    if ($urandom_range(0, 2) != 0)
                        load_system(n);
                    else
                        touch_and_solve(n);
                    if ($urandom_range(0, 5) == 0)
                        wait_drained();
                end
            end
            no_idle = 0;
            wait_drained();
        end

        // Make sure the long receiver stall happened at least once
        if (hold_req == 0) begin
            hold_req++;
            load_system(board.active_n());
            load_system(board.active_n());
        end
        wait_drained();
        repeat (100) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
